// File: rtl/core/rsos_pkg.sv
// Package for the range scan object segmenter core.
// Holds shared constants, types, the controller state and command structs,
// and the sine table generator. No dependencies.
`default_nettype none

package rsos_pkg;

   localparam int RSOS_MAX_OBJECTS = 8;
   localparam int RSOS_SINE_BITS   = 16;

   localparam int RANGE_W = 16;
   localparam int ANGLE_W = 8;
   localparam int SUM_W   = 24;
   localparam int TALLY_W = 8;
   localparam int COUNT_W = 4;
   localparam int CHORD_W = 17;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CHORD_W-1:0] CHORD_MAX = '1;
   localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
   localparam int SINE_LAST = 180;

   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WIDTH      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECT_LIMIT   = 2'd2;

   typedef enum logic [1:0] {
      KIND_OBJECT   = 2'd0,
      KIND_SMALLEST = 2'd1,
      KIND_NONE     = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_MUL,
      ST_CHORD,
      ST_REC,
      ST_REP
   } state_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic mul;
      logic chord;
      logic load_rec;
      logic load_rep;
   } cmd_type;

   typedef struct packed {
      logic close_ok;
      logic scan_end;
      logic div_done;
      logic out_full;
   } status_type;

   function automatic logic [18:0] sine_entry(int unsigned k, int unsigned bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] acc;
      logic [63:0] r;
      int unsigned kk;
      kk = (k > 360) ? 360 : k;
      if (kk > 180) kk = 360 - kk;
      x = (64'd3373259426 * 64'(kk)) / 64'd360;
      x2 = (x * x) >> 30;
      term = x;
      acc = signed'(x);
      for (int n = 1; n <= 10; n++) begin
         term = (term * x2) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) acc = acc - signed'(term);
         else acc = acc + signed'(term);
      end
      if (acc < 0) acc = 0;
      r = (64'(acc) + (64'd1 << (29 - bits))) >> (30 - bits);
      return r[18:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/rsos_divider.sv
// Restoring divider for the object mean: 24-bit sum by 8-bit tally.
// One quotient bit per cycle. Depends on rsos_pkg.
`default_nettype none

module rsos_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [rsos_pkg::SUM_W-1:0]   dividend,
   input  wire logic [rsos_pkg::TALLY_W-1:0] divisor,
   output logic                             done,
   output logic [rsos_pkg::SUM_W-1:0]        quotient
);
   import rsos_pkg::*;

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [TALLY_W-1:0]  rem_ff, rem_in;
   logic [TALLY_W-1:0]  den_ff, den_in;
   logic [TALLY_W:0]    shifted;
   logic                fits;

   always_comb begin
      shifted  = {rem_ff, quo_ff[SUM_W-1]};
      fits     = shifted >= {1'b0, den_ff};
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(SUM_W);
         quo_in   = dividend;
         rem_in   = '0;
         den_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[SUM_W-2:0], fits};
         rem_in   = fits ? TALLY_W'(shifted - {1'b0, den_ff}) : shifted[TALLY_W-1:0];
         count_in = count_ff - CNT_W'(1);
         busy_in  = count_ff != CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = !busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: rtl/core/rsos_datapath.sv
// Datapath of the segmenter: scan state, edge tests, mean, chord, best object
// tracking, configuration registers and the result register.
// Depends on rsos_pkg and rsos_divider.
`default_nettype none

module rsos_datapath #(
   parameter int MAX_OBJECTS     = rsos_pkg::RSOS_MAX_OBJECTS,
   parameter int SINE_TABLE_BITS = rsos_pkg::RSOS_SINE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rsos_pkg::cmd_type             cmd,
   output rsos_pkg::status_type               status,
   input  wire logic [rsos_pkg::RANGE_W-1:0]   in_range,
   input  wire logic [rsos_pkg::ANGLE_W-1:0]   in_angle,
   input  wire logic                          in_start,
   input  wire logic                          in_end,
   input  wire logic                          csr_we,
   input  wire logic [rsos_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rsos_pkg::CSR_W-1:0]     csr_wdata,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output rsos_pkg::kind_type                 out_kind,
   output logic [rsos_pkg::COUNT_W-1:0]        out_id,
   output logic [rsos_pkg::ANGLE_W-1:0]        out_first,
   output logic [rsos_pkg::ANGLE_W-1:0]        out_final,
   output logic [rsos_pkg::ANGLE_W-1:0]        out_centre,
   output logic [rsos_pkg::ANGLE_W-1:0]        out_arc,
   output logic [rsos_pkg::RANGE_W-1:0]        out_mean,
   output logic [rsos_pkg::CHORD_W-1:0]        out_chord,
   output logic                               out_last
);
   import rsos_pkg::*;

   localparam int SW = SINE_TABLE_BITS + 1;
   localparam int PW = RANGE_W + SW;
   localparam int CW = PW + 2;

   logic [SW-1:0] sine_rom [0:SINE_LAST];
   for (genvar g = 0; g <= SINE_LAST; g++) begin : g_sine
      assign sine_rom[g] = SW'(sine_entry(g, SINE_TABLE_BITS));
   end

   // Configuration.
   logic [RANGE_W-1:0] thr_ff;
   logic [ANGLE_W-1:0] min_w_ff;
   logic [COUNT_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= RANGE_W'(40);
         min_w_ff <= ANGLE_W'(4);
         limit_ff <= COUNT_W'(8);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_EDGE_THRESHOLD: thr_ff   <= csr_wdata[RANGE_W-1:0];
            CSR_MIN_WIDTH:      min_w_ff <= csr_wdata[ANGLE_W-1:0];
            CSR_OBJECT_LIMIT:   limit_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Captured input word.
   logic [RANGE_W-1:0] range_ff;
   logic [ANGLE_W-1:0] angle_ff;
   logic               start_ff;
   logic               end_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         range_ff <= in_range;
         angle_ff <= in_angle;
         start_ff <= in_start;
         end_ff   <= in_end;
      end
   end

   // Scan state.
   logic               hist_ff, hist_in;
   logic               inside_ff, inside_in;
   logic [ANGLE_W-1:0] open_ff, open_in;
   logic [ANGLE_W-1:0] last_a_ff;
   logic [RANGE_W-1:0] last_r_ff;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic [COUNT_W-1:0] found_ff, found_in;
   logic [CHORD_W-1:0] best_chord_ff, best_chord_in;
   logic [COUNT_W-1:0] best_id_ff, best_id_in;
   logic [ANGLE_W-1:0] best_centre_ff, best_centre_in;
   logic               best_valid_ff, best_valid_in;

   logic [ANGLE_W-1:0] eff_last_a;
   logic [RANGE_W-1:0] eff_last_r;
   logic [RANGE_W:0]   drop, rise;
   logic [ANGLE_W:0]   width;
   logic [COUNT_W-1:0] cap;
   logic               close_ok;
   logic [ANGLE_W:0]   centre_sum;

   // Object job registers.
   logic [ANGLE_W-1:0] job_first_ff, job_final_ff, job_centre_ff, job_w_ff, job_k_ff;
   logic [ANGLE_W-1:0] job_k;
   logic [SW-1:0]      sine_ff;
   logic [PW-1:0]      prod_ff;
   logic [RANGE_W-1:0] mean_ff;
   logic [CHORD_W-1:0] chord_ff;
   logic [CW-1:0]      chord_sum, chord_shr;
   logic [CHORD_W-1:0] chord;
   logic [COUNT_W-1:0] new_id;

   logic               div_done;
   logic [SUM_W-1:0]   quotient;
   logic [TALLY_W-1:0] divisor;

   always_comb begin
      hist_in        = start_ff ? 1'b0 : hist_ff;
      inside_in      = start_ff ? 1'b0 : inside_ff;
      open_in        = start_ff ? '0 : open_ff;
      eff_last_a     = start_ff ? '0 : last_a_ff;
      eff_last_r     = start_ff ? '0 : last_r_ff;
      sum_in         = start_ff ? '0 : sum_ff;
      tally_in       = start_ff ? '0 : tally_ff;
      found_in       = start_ff ? '0 : found_ff;
      best_chord_in  = start_ff ? CHORD_MAX : best_chord_ff;
      best_id_in     = start_ff ? '0 : best_id_ff;
      best_centre_in = start_ff ? '0 : best_centre_ff;
      best_valid_in  = start_ff ? 1'b0 : best_valid_ff;

      drop = {1'b0, eff_last_r} - {1'b0, range_ff};
      rise = {1'b0, range_ff} - {1'b0, eff_last_r};
      width = {1'b0, eff_last_a} - {1'b0, open_in};
      cap = (limit_ff < COUNT_W'(MAX_OBJECTS)) ? limit_ff : COUNT_W'(MAX_OBJECTS);
      centre_sum = {1'b0, open_in} + {1'b0, eff_last_a};
      close_ok = 1'b0;

      if (!hist_in) begin
         hist_in = 1'b1;
      end else if (!inside_in) begin
         if (!drop[RANGE_W] && drop[RANGE_W-1:0] > thr_ff) begin
            inside_in = 1'b1;
            open_in   = angle_ff;
            sum_in    = SUM_W'(range_ff);
            tally_in  = TALLY_W'(1);
         end
      end else if (!rise[RANGE_W] && rise[RANGE_W-1:0] > thr_ff) begin
         inside_in = 1'b0;
         close_ok  = !width[ANGLE_W] && width[ANGLE_W-1:0] >= min_w_ff && found_in < cap;
      end else if (tally_in < TALLY_MAX) begin
         sum_in   = sum_in + SUM_W'(range_ff);
         tally_in = tally_in + TALLY_W'(1);
      end

      divisor = (tally_in == '0) ? TALLY_W'(1) : tally_in;
      job_k = (width[ANGLE_W-1:0] > ANGLE_W'(SINE_LAST))
            ? ANGLE_W'(9'd360 - width) : width[ANGLE_W-1:0];

      chord_sum = CW'({prod_ff, 1'b0}) + (CW'(1) << (SINE_TABLE_BITS - 1));
      chord_shr = chord_sum >> SINE_TABLE_BITS;
      chord = (chord_shr > CW'(CHORD_MAX)) ? CHORD_MAX : chord_shr[CHORD_W-1:0];
      new_id = found_ff + COUNT_W'(1);
   end

   rsos_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.eval && close_ok),
      .dividend (sum_in),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff        <= 1'b0;
         inside_ff      <= 1'b0;
         open_ff        <= '0;
         last_a_ff      <= '0;
         last_r_ff      <= '0;
         sum_ff         <= '0;
         tally_ff       <= '0;
         found_ff       <= '0;
         best_chord_ff  <= CHORD_MAX;
         best_id_ff     <= '0;
         best_centre_ff <= '0;
         best_valid_ff  <= 1'b0;
      end else if (cmd.eval) begin
         hist_ff        <= hist_in;
         inside_ff      <= inside_in;
         open_ff        <= open_in;
         last_a_ff      <= angle_ff;
         last_r_ff      <= range_ff;
         sum_ff         <= sum_in;
         tally_ff       <= tally_in;
         found_ff       <= found_in;
         best_chord_ff  <= best_chord_in;
         best_id_ff     <= best_id_in;
         best_centre_ff <= best_centre_in;
         best_valid_ff  <= best_valid_in;
      end else if (cmd.chord) begin
         found_ff <= new_id;
         if (!best_valid_ff || chord < best_chord_ff) begin
            best_valid_ff  <= 1'b1;
            best_chord_ff  <= chord;
            best_id_ff     <= new_id;
            best_centre_ff <= job_centre_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval && close_ok) begin
         job_first_ff  <= open_in;
         job_final_ff  <= eff_last_a;
         job_centre_ff <= centre_sum[ANGLE_W:1];
         job_w_ff      <= width[ANGLE_W-1:0];
         job_k_ff      <= job_k;
      end
      sine_ff <= sine_rom[job_k_ff];
      if (cmd.mul) begin
         prod_ff <= quotient[RANGE_W-1:0] * sine_ff;
         mean_ff <= quotient[RANGE_W-1:0];
      end
      if (cmd.chord) chord_ff <= chord;
   end

   // Result register.
   logic out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_rec || cmd.load_rep) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rec) begin
         out_kind   <= KIND_OBJECT;
         out_id     <= found_ff;
         out_first  <= job_first_ff;
         out_final  <= job_final_ff;
         out_centre <= job_centre_ff;
         out_arc    <= job_w_ff;
         out_mean   <= mean_ff;
         out_chord  <= chord_ff;
         out_last   <= !end_ff;
      end else if (cmd.load_rep) begin
         out_kind   <= best_valid_ff ? KIND_SMALLEST : KIND_NONE;
         out_id     <= best_valid_ff ? best_id_ff : '0;
         out_first  <= '0;
         out_final  <= '0;
         out_centre <= best_valid_ff ? best_centre_ff : '0;
         out_arc    <= '0;
         out_mean   <= '0;
         out_chord  <= best_valid_ff ? best_chord_ff : '0;
         out_last   <= 1'b1;
      end
   end

   assign out_valid       = out_valid_ff;
   assign status.close_ok = close_ok;
   assign status.scan_end = end_ff;
   assign status.div_done = div_done;
   assign status.out_full = out_valid_ff;

endmodule

`default_nettype wire

// File: rtl/core/rsos_ctrl.sv
// Controller state machine of the segmenter: sequences evaluation, division,
// multiply, chord and result loads. Depends on rsos_pkg.
`default_nettype none

module rsos_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire rsos_pkg::status_type status,
   output rsos_pkg::cmd_type         cmd
);
   import rsos_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready    = 1'b1;
            cmd.capture = in_valid;
            if (in_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (status.close_ok) state_in = ST_DIV;
            else if (status.scan_end) state_in = ST_REP;
            else state_in = ST_IDLE;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CHORD;
         end
         ST_CHORD: begin
            cmd.chord = 1'b1;
            state_in  = ST_REC;
         end
         ST_REC: begin
            if (!status.out_full) begin
               cmd.load_rec = 1'b1;
               state_in     = status.scan_end ? ST_REP : ST_IDLE;
            end
         end
         ST_REP: begin
            if (!status.out_full) begin
               cmd.load_rep = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/range_scan_object_segmenter_core.sv
// Top level of the range scan object segmenter core.
// Instantiates rsos_ctrl and rsos_datapath; depends on rsos_pkg.
//
//   Channel  Direction  Handshake                  Content
//   req_     in         req_tvalid / req_tready    range and angle, scan start, scan end
//   rsp_     out        rsp_tvalid / rsp_tready    object record or scan report
//   csr_     in         csr_we                     edge threshold, min width, limit
//
// A word that closes an accepted object goes from acceptance to its record
// through evaluation, the bit-serial mean division (24 steps, then the done
// check), multiply, chord and the record load. Other words go through
// evaluation alone, or evaluation and a scan report.
// Synchronous reset clears control, scan and valid state and loads default settings.
// A result waits in the output register while the next word is accepted; a
// word's results stall only while that register is still full.
`default_nettype none

module range_scan_object_segmenter_core #(
   parameter int MAX_OBJECTS     = rsos_pkg::RSOS_MAX_OBJECTS,
   parameter int SINE_TABLE_BITS = rsos_pkg::RSOS_SINE_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // range_cm100[15:0], angle_deg[23:16]
   input  wire logic        req_tuser,   // scan_start
   input  wire logic        req_tlast,   // scan_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // object_id[3:0], first_angle[11:4], final_angle[19:12], centre_angle[27:20],
   // arc_width[35:28], mean_range[51:36], chord_width[68:52], zero[71:69]
   output logic [71:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,   // record_kind
   output logic             rsp_tlast,   // last_of_run
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import rsos_pkg::*;

   cmd_type    cmd;
   status_type status;
   kind_type   out_kind;

   logic [COUNT_W-1:0] out_id;
   logic [ANGLE_W-1:0] out_first, out_final, out_centre, out_arc;
   logic [RANGE_W-1:0] out_mean;
   logic [CHORD_W-1:0] out_chord;

   rsos_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   rsos_datapath #(
      .MAX_OBJECTS     (MAX_OBJECTS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_range   (req_tdata[15:0]),
      .in_angle   (req_tdata[23:16]),
      .in_start   (req_tuser),
      .in_end     (req_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_kind   (out_kind),
      .out_id     (out_id),
      .out_first  (out_first),
      .out_final  (out_final),
      .out_centre (out_centre),
      .out_arc    (out_arc),
      .out_mean   (out_mean),
      .out_chord  (out_chord),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, out_chord, out_mean, out_arc, out_centre,
                       out_final, out_first, out_id};
   assign rsp_tuser = out_kind;

endmodule

`default_nettype wire

// File: sim/rsos_checker.sv
// Result checker for the range scan object segmenter core. It watches the request,
// result and register channels, predicts every result word and compares it field
// by field. Depends on rsos_pkg.
module rsos_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [23:0] req_tdata,   // range_cm100[15:0], angle_deg[23:16]
   input  wire logic        req_tuser,   // scan_start
   input  wire logic        req_tlast,   // scan_end
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // object_id[3:0], first_angle[11:4], final_angle[19:12], centre_angle[27:20],
   // arc_width[35:28], mean_range[51:36], chord_width[68:52], zero[71:69]
   input  wire logic [71:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,   // record_kind
   input  wire logic        rsp_tlast,   // last_of_run
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output int               fail_count,
   output int               backlog
);
   timeunit 1ns;
   timeprecision 1ps;
   import rsos_pkg::*;

   typedef struct {
      kind_type    kind;
      logic [3:0]  id;
      logic [7:0]  open_deg;
      logic [7:0]  shut_deg;
      logic [7:0]  mid_deg;
      logic [7:0]  arc_deg;
      logic [15:0] mean;
      logic [16:0] chord;
      logic        tail;
   } seg_record_type;

   seg_record_type expected_records[$];
   logic [18:0] sine_lut [0:SINE_LAST];

   logic [15:0] edge_step;
   logic [7:0]  narrowest_arc;
   logic [3:0]  record_cap;

   logic        primed;
   logic        tracking;
   logic        best_set;
   logic [7:0]  start_deg;
   logic [7:0]  prev_deg;
   logic [7:0]  best_mid;
   logic [15:0] prev_range;
   logic [23:0] range_acc;
   logic [7:0]  range_hits;
   logic [3:0]  objects_seen;
   logic [3:0]  best_id;
   logic [16:0] best_chord;

   // Sine of k half degrees, from a Q30 Taylor series rounded to the table precision.
   function automatic logic [18:0] half_degree_sine(int unsigned k);
      longint unsigned ang;
      longint unsigned ang_sq;
      longint unsigned term;
      longint          total;
      ang = (64'd3373259426 * 64'(k)) / 64'd360;
      ang_sq = (ang * ang) >> 30;
      term = ang;
      total = longint'(ang);
      for (int n = 1; n <= 10; n++) begin
         term = (term * ang_sq) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) total = total - longint'(term);
         else total = total + longint'(term);
      end
      if (total < 0) total = 0;
      term = 64'(total);
      return 19'((term + (64'd1 << (29 - RSOS_SINE_BITS))) >> (30 - RSOS_SINE_BITS));
   endfunction

   initial begin
      for (int k = 0; k <= SINE_LAST; k++) sine_lut[k] = half_degree_sine(k);
   end

   function automatic seg_record_type blank_record(kind_type k);
      seg_record_type r;
      r.kind = k;
      r.id = '0;
      r.open_deg = '0;
      r.shut_deg = '0;
      r.mid_deg = '0;
      r.arc_deg = '0;
      r.mean = '0;
      r.chord = '0;
      r.tail = 1'b0;
      return r;
   endfunction

   task automatic clear_scan();
      primed = 1'b0;
      tracking = 1'b0;
      start_deg = '0;
      prev_deg = '0;
      prev_range = '0;
      range_acc = '0;
      range_hits = '0;
      objects_seen = '0;
      best_chord = CHORD_MAX;
      best_id = '0;
      best_mid = '0;
      best_set = 1'b0;
   endtask

   task automatic log_mismatch(string what);
      if (fail_count < 40) $display("%0t ns mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic segment_sample(logic [15:0] rng, logic [7:0] ang, logic first_flag,
                                 logic end_flag);
      int              arc;
      int unsigned     cap;
      int unsigned     divisor;
      logic [15:0]     mean_v;
      longint unsigned chord_v;
      seg_record_type  rec;
      int              made;
      made = 0;
      if (first_flag) clear_scan();
      if (!primed) begin
         primed = 1'b1;
      end else if (!tracking) begin
         if (int'(prev_range) - int'(rng) > int'(edge_step)) begin
            tracking = 1'b1;
            start_deg = ang;
            range_acc = 24'(rng);
            range_hits = 8'd1;
         end
      end else if (int'(rng) - int'(prev_range) > int'(edge_step)) begin
         arc = int'(prev_deg) - int'(start_deg);
         cap = (record_cap < RSOS_MAX_OBJECTS) ? record_cap : RSOS_MAX_OBJECTS;
         tracking = 1'b0;
         if (arc >= int'(narrowest_arc) && objects_seen < cap) begin
            divisor = (range_hits != 0) ? range_hits : 1;
            mean_v = 16'(range_acc / divisor);
            chord_v = (64'd2 * mean_v * sine_lut[(arc > SINE_LAST) ? 360 - arc : arc]
                       + (64'd1 << (RSOS_SINE_BITS - 1))) >> RSOS_SINE_BITS;
            if (chord_v > CHORD_MAX) chord_v = CHORD_MAX;
            rec = blank_record(KIND_OBJECT);
            rec.id = objects_seen + 4'd1;
            rec.open_deg = start_deg;
            rec.shut_deg = prev_deg;
            rec.mid_deg = 8'((int'(start_deg) + int'(prev_deg)) / 2);
            rec.arc_deg = 8'(arc);
            rec.mean = mean_v;
            rec.chord = 17'(chord_v);
            expected_records.push_back(rec);
            made++;
            if (!best_set || rec.chord < best_chord) begin
               best_set = 1'b1;
               best_chord = rec.chord;
               best_id = rec.id;
               best_mid = rec.mid_deg;
            end
            objects_seen = rec.id;
         end
      end else if (range_hits < TALLY_MAX) begin
         range_acc = range_acc + 24'(rng);
         range_hits++;
      end
      prev_range = rng;
      prev_deg = ang;
      if (end_flag) begin
         if (best_set) begin
            rec = blank_record(KIND_SMALLEST);
            rec.id = best_id;
            rec.mid_deg = best_mid;
            rec.chord = best_chord;
         end else begin
            rec = blank_record(KIND_NONE);
         end
         expected_records.push_back(rec);
         made++;
      end
      if (made > 0) expected_records[expected_records.size() - 1].tail = 1'b1;
   endtask

   task automatic cmp_field(string tag, logic [31:0] seen, logic [31:0] wanted);
      if (seen !== wanted) log_mismatch($sformatf("%s got %0d want %0d", tag, seen, wanted));
   endtask

   task automatic check_word();
      seg_record_type want;
      if (expected_records.size() == 0) begin
         log_mismatch($sformatf("unexpected word, kind %0d", rsp_tuser));
      end else begin
         want = expected_records.pop_front();
         cmp_field("record_kind", rsp_tuser, want.kind);
         cmp_field("object_id", rsp_tdata[3:0], want.id);
         cmp_field("first_angle", rsp_tdata[11:4], want.open_deg);
         cmp_field("final_angle", rsp_tdata[19:12], want.shut_deg);
         cmp_field("centre_angle", rsp_tdata[27:20], want.mid_deg);
         cmp_field("arc_width", rsp_tdata[35:28], want.arc_deg);
         cmp_field("mean_range", rsp_tdata[51:36], want.mean);
         cmp_field("chord_width", rsp_tdata[68:52], want.chord);
         cmp_field("padding", rsp_tdata[71:69], 0);
         cmp_field("last_of_run", rsp_tlast, want.tail);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         edge_step = 16'd40;
         narrowest_arc = 8'd4;
         record_cap = 4'd8;
         clear_scan();
         expected_records.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_EDGE_THRESHOLD: edge_step = csr_wdata;
               CSR_MIN_WIDTH:      narrowest_arc = csr_wdata[7:0];
               CSR_OBJECT_LIMIT:   record_cap = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) check_word();
         if (req_tvalid && req_tready) begin
            segment_sample(req_tdata[15:0], req_tdata[23:16], req_tuser, req_tlast);
         end
      end
      backlog = expected_records.size();
   end

endmodule

// File: sim/tb_top.sv
// Top of the segmenter testbench: drives sweep samples and register writes into the
// core, stalls the result side, and judges by the checker's fail count and backlog.
// Depends on rsos_pkg, range_scan_object_segmenter_core and rsos_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rsos_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT   = 5000;

   typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_CHOKE} rx_mode_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // range_cm100[15:0], angle_deg[23:16]
   logic        req_tuser;   // scan_start
   logic        req_tlast;   // scan_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   // object_id[3:0], first_angle[11:4], final_angle[19:12], centre_angle[27:20],
   // arc_width[35:28], mean_range[51:36], chord_width[68:52], zero[71:69]
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;   // record_kind
   logic        rsp_tlast;   // last_of_run
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   int          fail_count;
   int          backlog;
   int          items_sent;
   int          burst_left;

   range_scan_object_segmenter_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   rsos_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .backlog    (backlog)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      #30ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : result_side
      rx_mode_type mode;
      int          span;
      logic [15:0] pattern;
      rsp_tready = 1'b0;
      forever begin
         mode = rx_mode_type'($urandom_range(0, 3));
         span = $urandom_range(50, 300);
         pattern = 16'($urandom);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               RX_OPEN:    rsp_tready = 1'b1;
               RX_COIN:    rsp_tready = ($urandom_range(0, 9) < 7);
               RX_PATTERN: begin
                  rsp_tready = pattern[0];
                  pattern = {pattern[0], pattern[15:1]};
               end
               default:    rsp_tready = ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   task automatic put_sample(int rng, int ang, bit first_flag, bit end_flag);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {8'(ang), 16'(rng)};
      req_tuser = first_flag;
      req_tlast = end_flag;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic write_reg(logic [1:0] idx, int value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = 16'(value);
      @(posedge clock);
   endtask

   task automatic apply_settings(int edge_gap, int arc_min, int cap);
      write_reg(CSR_EDGE_THRESHOLD, edge_gap);
      write_reg(CSR_MIN_WIDTH, arc_min);
      write_reg(CSR_OBJECT_LIMIT, cap);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic wait_idle();
      int waited;
      waited = 0;
      @(negedge clock);
      req_tvalid = 1'b0;
      while (backlog != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // A sweep over near and far surfaces; most scans are framed by start and end.
   task automatic sweep_scan(int edge_gap, int n);
      int ang;
      int dir;
      int turn;
      int noise;
      int margin;
      int far_rng;
      int near_rng;
      int rng;
      bit near_side;
      noise = (edge_gap / 2 < 300) ? edge_gap / 2 : 300;
      margin = edge_gap + 1 + 2 * noise;
      dir = ($urandom_range(0, 9) == 0) ? -1 : 1;
      ang = (dir > 0) ? $urandom_range(0, 40) : $urandom_range(140, 180);
      near_side = 1'b0;
      far_rng = 0;
      near_rng = 0;
      for (int i = 0; i < n; i++) begin
         if (i == 0 || $urandom_range(0, 7) == 0) begin
            far_rng = (margin <= 65535) ? $urandom_range(margin, 65535) : $urandom_range(0, 65535);
            near_rng = (far_rng >= margin) ? $urandom_range(0, far_rng - margin) : 0;
         end
         if (i > 0 && $urandom_range(0, 4) == 0) near_side = !near_side;
         if ($urandom_range(0, 15) == 0) rng = $urandom_range(0, 65535);
         else if (near_side) rng = near_rng + $urandom_range(0, noise);
         else rng = far_rng - $urandom_range(0, noise);
         if (rng < 0) rng = 0;
         put_sample(rng, ang, i == 0 && $urandom_range(0, 5) != 0,
                    i == n - 1 && $urandom_range(0, 7) != 0);
         turn = $urandom_range(0, 4);
         ang = (dir > 0) ? ang + turn : ang - turn;
         if (ang < 0) ang = 0;
         if (ang > 180) ang = 180;
      end
   endtask

   task automatic stray_samples(int n);
      repeat (n) put_sample($urandom_range(0, 65535), $urandom_range(0, 180),
                            $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
   endtask

   // One object long enough that its sample count saturates.
   task automatic long_object_scan();
      int ang;
      ang = 0;
      put_sample(65535, 0, 1'b1, 1'b0);
      for (int i = 0; i < 270; i++) begin
         put_sample(65000 + $urandom_range(0, 30), ang, 1'b0, 1'b0);
         if (i % 4 == 3) ang++;
      end
      put_sample(65535, ang, 1'b0, 1'b0);
      put_sample(65535, ang + 1, 1'b0, 1'b1);
   endtask

   task automatic run_phase(int edge_gap, int arc_min, int cap, int budget);
      int first_item;
      apply_settings(edge_gap, arc_min, cap);
      first_item = items_sent;
      while (items_sent - first_item < budget) begin
         if ($urandom_range(0, 6) == 0) stray_samples($urandom_range(1, 4));
         else sweep_scan(edge_gap, $urandom_range(4, 24));
      end
      wait_idle();
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_EDGE_THRESHOLD;
      csr_wdata = '0;
      items_sent = 0;
      burst_left = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      put_sample(65535, 0, 1'b1, 1'b0);
      put_sample(0, 2, 1'b0, 1'b0);
      put_sample(0, 4, 1'b0, 1'b0);
      put_sample(0, 6, 1'b0, 1'b0);
      put_sample(65535, 8, 1'b0, 1'b0);
      put_sample(0, 10, 1'b0, 1'b0);
      put_sample(0, 14, 1'b0, 1'b0);
      put_sample(65535, 15, 1'b0, 1'b0);
      put_sample(1000, 16, 1'b0, 1'b0);
      put_sample(1000, 180, 1'b0, 1'b0);
      put_sample(50000, 180, 1'b0, 1'b1);
      put_sample(5000, 90, 1'b1, 1'b0);
      put_sample(4960, 100, 1'b0, 1'b0);
      put_sample(4919, 101, 1'b0, 1'b0);
      put_sample(4959, 102, 1'b0, 1'b0);
      put_sample(4000, 90, 1'b0, 1'b0);
      put_sample(60000, 80, 1'b0, 1'b1);
      put_sample(200, 0, 1'b1, 1'b1);
      put_sample(65535, 50, 1'b1, 1'b0);
      put_sample(100, 60, 1'b0, 1'b0);
      put_sample(100, 70, 1'b1, 1'b0);
      put_sample(65535, 80, 1'b0, 1'b1);
      wait_idle();

      run_phase(40, 4, 8, 40);
      long_object_scan();
      wait_idle();
      run_phase(0, 0, 1, 70);
      run_phase(65535, 180, 8, 25);
      run_phase(1000, 2, 0, 60);
      run_phase($urandom_range(0, 2000), $urandom_range(0, 30), $urandom_range(0, 8), 70);
      run_phase(500, 10, 7, 60);
      run_phase(200, 0, 2, 40);

      if (fail_count == 0 && backlog == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/rsos_pkg.sv
rtl/core/rsos_divider.sv
rtl/core/rsos_datapath.sv
rtl/core/rsos_ctrl.sv
rtl/core/range_scan_object_segmenter_core.sv
sim/rsos_checker.sv
sim/tb_top.sv
